>>> rtl/pressure_temperature_compensation_macros.svh
// Assertion macros for the pressure and temperature compensation block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ptc_pkg.sv
// Package for the pressure and temperature compensation block.
// Holds constants, the pipeline word type and arithmetic helpers; no dependencies.
package ptc_pkg;

  localparam int NUM_CAL_WORDS = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CAL_T1_T2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CAL_T3_P1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CAL_P2_P3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CAL_P4_P5 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CAL_P6_P7 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CAL_P8_P9 = 3'd5;

  localparam logic [31:0] FINE_OFFSET  = 32'd64000;
  localparam logic [31:0] PRESS_OFFSET = 32'd1048576;
  localparam logic [31:0] PRESS_SCALE  = 32'd3125;
  localparam logic [31:0] P1_BIAS      = 32'd32768;
  localparam logic [31:0] TEMP_ROUND   = 32'd128;
  localparam logic [31:0] TEMP_MULT    = 32'd5;

  localparam int PRE_STAGES = 11;
  localparam int DIV_STAGES = 32;
  localparam int DIV_FIRST  = PRE_STAGES;
  localparam int POST_FIRST = PRE_STAGES + DIV_STAGES;
  localparam int NUM_STAGES = POST_FIRST + 3;

  typedef struct packed {
    logic [19:0] adcp;
    logic [31:0] x1;
    logic [31:0] dd;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] fa;
    logic [31:0] m3;
    logic [31:0] fine;
    logic [31:0] temp;
    logic [31:0] pa;
    logic [31:0] q;
    logic [31:0] sq;
    logic [31:0] m5;
    logic [31:0] m2b;
    logic [31:0] b6;
    logic [31:0] c3;
    logic [31:0] b;
    logic [31:0] a1;
    logic [31:0] ap;
    logic [31:0] s;
    logic [31:0] dv;
    logic [31:0] pm;
    logic [31:0] dvd;
    logic [31:0] quo;
    logic [32:0] rem;
    logic        inv;
    logic        big;
    logic [31:0] p;
    logic [31:0] mpp;
    logic [31:0] m8;
    logic [31:0] mp9;
  } stage_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] x);
    sext16 = {{16{x[15]}}, x};
  endfunction

endpackage

>>> rtl/ptc_in_if.sv
// Input channel carrying one raw temperature and pressure sample per word.
// No dependencies.
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

>>> rtl/ptc_out_if.sv
// Result channel carrying compensated temperature and pressure per word.
// No dependencies.
interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_pa;
  logic               pressure_invalid;
  modport source (output valid, temperature_centi, pressure_pa, pressure_invalid,
                  input ready);
  modport sink (input valid, temperature_centi, pressure_pa, pressure_invalid,
                output ready);
endinterface

>>> rtl/ptc_cfg_if.sv
// Configuration write channel: register index and write data.
// No dependencies.
interface ptc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pressure_temperature_compensation.sv
// Fully pipelined: accepts one word per cycle while the output is not stalled.
// Eleven arithmetic stages, a 32-stage restoring divider (one quotient bit per
// stage) and three correction stages; the whole pipe holds on output stall.
// Synchronous active-low reset clears valid bits and calibration registers.
// Depends on ptc_pkg, ptc_in_if, ptc_out_if, ptc_cfg_if and the macros header.
`include "pressure_temperature_compensation_macros.svh"

module pressure_temperature_compensation (
  input logic       clk,
  input logic       rst_n,
  ptc_in_if.sink    in_ch,
  ptc_out_if.source out_ch,
  ptc_cfg_if.sink   cfg_ch
);

  localparam int LAST = ptc_pkg::NUM_STAGES - 1;

  logic [31:0] cal_r [ptc_pkg::NUM_CAL_WORDS];
  ptc_pkg::stage_t st_r [ptc_pkg::NUM_STAGES];
  ptc_pkg::stage_t st_nxt [ptc_pkg::NUM_STAGES];
  logic [ptc_pkg::NUM_STAGES-1:0] vld_r;
  logic [ptc_pkg::NUM_STAGES-1:0] vld_nxt;
  logic adv;
  logic in_acc;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, cal_r[ptc_pkg::CAL_T1_T2][15:0]};
  assign t2 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_T1_T2][31:16]);
  assign t3 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_T3_P1][15:0]);
  assign p1 = {16'd0, cal_r[ptc_pkg::CAL_T3_P1][31:16]};
  assign p2 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_P2_P3][15:0]);
  assign p3 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_P2_P3][31:16]);
  assign p4 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_P4_P5][15:0]);
  assign p5 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_P4_P5][31:16]);
  assign p6 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_P6_P7][15:0]);
  assign p7 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_P6_P7][31:16]);
  assign p8 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_P8_P9][15:0]);
  assign p9 = ptc_pkg::sext16(cal_r[ptc_pkg::CAL_P8_P9][31:16]);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptc_pkg::NUM_CAL_WORDS; i++) cal_r[i] <= '0;
    end else if (cfg_ch.valid && 32'(cfg_ch.index) < ptc_pkg::NUM_CAL_WORDS) begin
      cal_r[cfg_ch.index] <= cfg_ch.data;
    end
  end

  assign adv = !vld_r[LAST] || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc = in_ch.valid && adv;
  assign vld_nxt = {vld_r[LAST-1:0], in_ch.valid};

  always_comb begin
    logic [32:0] trial;
    st_nxt[0] = st_r[0];
    for (int k = 1; k < ptc_pkg::NUM_STAGES; k++) st_nxt[k] = st_r[k-1];

    st_nxt[0].adcp = in_ch.raw_pressure;
    st_nxt[0].x1   = ({12'd0, in_ch.raw_temperature} >> 3) - (t1 << 1);
    st_nxt[0].dd   = ({12'd0, in_ch.raw_temperature} >> 4) - t1;

    st_nxt[1].m1 = st_r[0].x1 * t2;
    st_nxt[1].m2 = st_r[0].dd * st_r[0].dd;

    st_nxt[2].fa = ptc_pkg::asr(st_r[1].m1, 5'd11);
    st_nxt[2].m3 = ptc_pkg::asr(st_r[1].m2, 5'd12) * t3;

    st_nxt[3].fine = st_r[2].fa + ptc_pkg::asr(st_r[2].m3, 5'd14);

    st_nxt[4].temp = ptc_pkg::asr(st_r[3].fine * ptc_pkg::TEMP_MULT + ptc_pkg::TEMP_ROUND,
                                  5'd8);
    st_nxt[4].pa = ptc_pkg::asr(st_r[3].fine, 5'd1) - ptc_pkg::FINE_OFFSET;
    st_nxt[4].q  = ptc_pkg::asr(ptc_pkg::asr(st_r[3].fine, 5'd1) - ptc_pkg::FINE_OFFSET,
                                5'd2);

    st_nxt[5].sq  = st_r[4].q * st_r[4].q;
    st_nxt[5].m5  = st_r[4].pa * p5;
    st_nxt[5].m2b = p2 * st_r[4].pa;

    st_nxt[6].b6 = ptc_pkg::asr(st_r[5].sq, 5'd11) * p6;
    st_nxt[6].c3 = p3 * ptc_pkg::asr(st_r[5].sq, 5'd13);

    st_nxt[7].b  = ptc_pkg::asr(st_r[6].b6 + (st_r[6].m5 << 1), 5'd2) + (p4 << 16);
    st_nxt[7].a1 = ptc_pkg::P1_BIAS + ptc_pkg::asr(ptc_pkg::asr(st_r[6].c3, 5'd3)
                   + ptc_pkg::asr(st_r[6].m2b, 5'd1), 5'd18);

    st_nxt[8].ap = st_r[7].a1 * p1;
    st_nxt[8].s  = (ptc_pkg::PRESS_OFFSET - {12'd0, st_r[7].adcp})
                   - ptc_pkg::asr(st_r[7].b, 5'd12);

    st_nxt[9].dv = ptc_pkg::asr(st_r[8].ap, 5'd15);
    st_nxt[9].pm = st_r[8].s * ptc_pkg::PRESS_SCALE;

    st_nxt[10].inv = (st_r[9].dv == 32'd0);
    st_nxt[10].big = st_r[9].pm[31];
    st_nxt[10].dvd = st_r[9].pm[31] ? st_r[9].pm : (st_r[9].pm << 1);
    st_nxt[10].rem = '0;
    st_nxt[10].quo = '0;

    for (int k = ptc_pkg::DIV_FIRST; k < ptc_pkg::POST_FIRST; k++) begin
      trial = {st_r[k-1].rem[31:0], st_r[k-1].dvd[31]};
      st_nxt[k].dvd = st_r[k-1].dvd << 1;
      if (trial >= {1'b0, st_r[k-1].dv}) begin
        st_nxt[k].rem = trial - {1'b0, st_r[k-1].dv};
        st_nxt[k].quo = {st_r[k-1].quo[30:0], 1'b1};
      end else begin
        st_nxt[k].rem = trial;
        st_nxt[k].quo = {st_r[k-1].quo[30:0], 1'b0};
      end
    end

    st_nxt[ptc_pkg::POST_FIRST].p = st_r[ptc_pkg::POST_FIRST-1].big
      ? (st_r[ptc_pkg::POST_FIRST-1].quo << 1) : st_r[ptc_pkg::POST_FIRST-1].quo;
    st_nxt[ptc_pkg::POST_FIRST].mpp = (st_nxt[ptc_pkg::POST_FIRST].p >> 3)
                                      * (st_nxt[ptc_pkg::POST_FIRST].p >> 3);
    st_nxt[ptc_pkg::POST_FIRST].m8 = (st_nxt[ptc_pkg::POST_FIRST].p >> 2) * p8;

    st_nxt[ptc_pkg::POST_FIRST+1].mp9 = p9 * (st_r[ptc_pkg::POST_FIRST].mpp >> 13);

    st_nxt[LAST].p = st_r[LAST-1].inv ? 32'd0 : st_r[LAST-1].p + ptc_pkg::asr(
      ptc_pkg::asr(st_r[LAST-1].mp9, 5'd12) + ptc_pkg::asr(st_r[LAST-1].m8, 5'd13) + p7,
      5'd4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ptc_pkg::NUM_STAGES; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign out_ch.valid             = vld_r[LAST];
  assign out_ch.temperature_centi = $signed(st_r[LAST].temp);
  assign out_ch.pressure_pa       = st_r[LAST].p;
  assign out_ch.pressure_invalid  = st_r[LAST].inv;

  `PTC_ASSERT_NOW(a_inv_zero, out_ch.valid && out_ch.pressure_invalid, out_ch.pressure_pa == 32'd0)
  `PTC_ASSERT_NEXT(a_enter, in_acc, vld_r[0])
  `PTC_ASSERT_NEXT(a_hold, !adv, $stable(vld_r))

endmodule

>>> bench/pressure_temperature_compensation_tb.sv
// Testbench for the pressure and temperature compensation block: drives raw
// samples and calibration writes, predicts each result and checks it in order.
// Depends on ptc_pkg, ptc_in_if, ptc_out_if, ptc_cfg_if and the DUT module.
module pressure_temperature_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } sample_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        inv;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptc_in_if in_ch();
  ptc_out_if out_ch();
  ptc_cfg_if cfg_ch();

  pressure_temperature_compensation DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [31:0] cal_word [ptc_pkg::NUM_CAL_WORDS];
  sample_t pending_samples[$];
  reading_t expected_readings[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  bit cfg_busy = 1'b0;

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] sx(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic reading_t compensate(input sample_t s);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, p, adt, adp;
    reading_t r;
    adt = {12'd0, s.raw_t};
    adp = {12'd0, s.raw_p};
    t1 = {16'd0, cal_word[0][15:0]};
    t2 = sx(cal_word[0][31:16]);
    t3 = sx(cal_word[1][15:0]);
    p1 = {16'd0, cal_word[1][31:16]};
    p2 = sx(cal_word[2][15:0]);
    p3 = sx(cal_word[2][31:16]);
    p4 = sx(cal_word[3][15:0]);
    p5 = sx(cal_word[3][31:16]);
    p6 = sx(cal_word[4][15:0]);
    p7 = sx(cal_word[4][31:16]);
    p8 = sx(cal_word[5][15:0]);
    p9 = sx(cal_word[5][31:16]);
    a = sra(((adt >> 3) - (t1 << 1)) * t2, 11);
    d = (adt >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    fine = a + b;
    r.temp = sra(fine * 32'd5 + 32'd128, 8);
    a = sra(fine, 1) - 32'd64000;
    b = sra(sra(a, 2) * sra(a, 2), 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(sra(a, 2) * sra(a, 2), 13), 3) + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    r.inv = 1'b0;
    if (a == 32'd0) begin
      p = 32'd0;
      r.inv = 1'b1;
    end else begin
      p = ((32'd1048576 - adp) - sra(b, 12)) * 32'd3125;
      if (p < 32'h80000000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra((p >> 2) * p8, 13);
      p = p + sra(a + b + p7, 4);
    end
    r.press = p;
    return r;
  endfunction

  // The input driver offers the queue head; a sample is accepted on valid and ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_readings.push_back(compensate(pending_samples.pop_front()));
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.raw_temperature <= pending_samples[0].raw_t;
        in_ch.raw_pressure <= pending_samples[0].raw_p;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // The hold-off counter keeps the receiver stalled for a long stretch.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // The result monitor compares each accepted word with the oldest prediction.
  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result word");
        end else begin
          want = expected_readings.pop_front();
          if (out_ch.temperature_centi !== want.temp || out_ch.pressure_pa !== want.press ||
              out_ch.pressure_invalid !== want.inv) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                       $signed(want.temp), want.press, want.inv, out_ch.temperature_centi,
                       out_ch.pressure_pa, out_ch.pressure_invalid);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_cal(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx < ptc_pkg::NUM_CAL_WORDS) cal_word[idx] = val;
  endtask

  task automatic drain;
    while (pending_samples.size() != 0 || expected_readings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_cal(input int mode);
    logic [31:0] w;
    for (int i = 0; i < ptc_pkg::NUM_CAL_WORDS; i++) begin
      case (mode)
        0: w = 32'd0;
        1: w = 32'hFFFFFFFF;
        2: w = (i == 0) ? {16'd26435, 16'd27504} : (i == 1) ? {16'd36477, 16'hFC18} :
               (i == 2) ? {16'd3024, 16'hD5D0} : (i == 3) ? {16'hFF7F, 16'd2855} :
               (i == 4) ? {16'd15500, 16'd140} : {16'd6000, 16'hC6F8};
        3: w = 32'h80008000;
        default: w = $urandom;
      endcase
      write_cal(ptc_pkg::CFG_IDX_W'(i), w);
    end
  endtask

  function automatic sample_t rand_sample(input bit realistic);
    sample_t s;
    if (realistic) begin
      s.raw_t = 20'($urandom_range(400000, 600000));
      s.raw_p = 20'($urandom_range(250000, 450000));
    end else begin
      s.raw_t = 20'($urandom);
      s.raw_p = 20'($urandom);
    end
    return s;
  endfunction

  initial begin
    int modes[8] = '{2, 0, 1, 3, 2, 4, 4, 2};
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int i = 0; i < ptc_pkg::NUM_CAL_WORDS; i++) cal_word[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: zero divisor with reset calibration, then field extremes.
    pending_samples.push_back('{20'd0, 20'd0});
    pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
    drain();
    write_cal(3'd7, 32'hFFFFFFFF);
    load_cal(2);
    pending_samples.push_back('{20'd519888, 20'd415148});
    pending_samples.push_back('{20'd0, 20'hFFFFF});
    pending_samples.push_back('{20'hFFFFF, 20'd0});
    pending_samples.push_back('{20'h55555, 20'hAAAAA});
    pending_samples.push_back('{20'hAAAAA, 20'h55555});
    pending_samples.push_back('{20'd0, 20'd0});
    pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      load_cal(modes[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (ph == 4) hold_off_cycles = 300;
      for (int k = 0; k < 205; k++) pending_samples.push_back(rand_sample($urandom_range(3) != 0));
      drain();
    end
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule
